// ----- rtl/sorted_batch_despike_mean_assert.svh -----
// Assertion macros shared by the sorted batch despike mean block.
`ifndef SORTED_BATCH_DESPIKE_MEAN_ASSERT_SVH
`define SORTED_BATCH_DESPIKE_MEAN_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define SBDM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define SBDM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/sbdm_pkg.sv -----
// Shared constants and control types of the sorted batch despike mean block.
package sbdm_pkg;

	localparam int DEPTH_DEF = 10;
	localparam int SAMPLE_W  = 16;
	localparam int FRAC_W    = 4;
	localparam int MEAN_W    = SAMPLE_W + FRAC_W;
	localparam int COUNT_W   = 5;
	localparam int THR_W     = 16;
	localparam int DATA_W    = 32;
	localparam int ADDR_W    = 2;

	localparam logic [THR_W-1:0] THR_RESET = THR_W'(50);

	// Register byte offsets
	localparam logic [ADDR_W-1:0] REG_SPIKE_THRESHOLD = ADDR_W'(0);

	// Commands from the controller to the datapath
	typedef struct packed {
		logic shift_in;
		logic sort_en;
		logic sort_odd;
		logic acc_clr;
		logic scan_en;
		logic scan_edge;
		logic scan_acc;
		logic div_en;
		logic out_load;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic sample_nz;
	} status_t;

endpackage

// ----- rtl/sbdm_cfg.sv -----
// APB register file holding the spike threshold.
module sbdm_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [sbdm_pkg::ADDR_W-1:0]  paddr,
	input  logic [sbdm_pkg::DATA_W-1:0]  pwdata,
	output logic [sbdm_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	output logic [sbdm_pkg::THR_W-1:0]   threshold
);
	import sbdm_pkg::*;

	logic [THR_W-1:0] thr_q;
	logic             wr_en;

	// Decode a write transaction; the only register takes the low THR_W bits of the word
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (wr_en) begin
			thr_q <= pwdata[THR_W-1:0];
		end
	end

	// Return the threshold at its offset, zero in the unused lanes
	always_comb begin
		prdata = '0;
		if (paddr == REG_SPIKE_THRESHOLD) begin
			prdata = DATA_W'(thr_q);
		end
	end

	assign threshold = thr_q;

endmodule

// ----- rtl/sbdm_ctrl.sv -----
// Controller state machine: fill, sort, despike scan, divide and emit.
module sbdm_ctrl #(
	parameter int DEPTH = sbdm_pkg::DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  sbdm_pkg::status_t status,
	output sbdm_pkg::cmd_t    cmd
);
	import sbdm_pkg::*;

	localparam int SUM_W  = MEAN_W + $clog2(DEPTH);
	localparam int FILL_W = $clog2(DEPTH);
	localparam int STEP_W = $clog2(SUM_W);

	typedef enum logic [2:0] {
		ST_FILL,
		ST_SORT,
		ST_SCAN,
		ST_DIV,
		ST_EMIT
	} state_t;

	state_t            state_q;
	logic [FILL_W-1:0] fill_q;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic              take;
	logic              batch_last;
	logic              pass_last;
	logic              div_last;
	logic              slot_free;

	assign in_ready   = (state_q == ST_FILL);
	assign out_valid  = out_valid_q;
	assign take       = in_valid && in_ready && status.sample_nz;
	assign batch_last = (fill_q == FILL_W'(DEPTH - 1));
	assign pass_last  = (step_q == STEP_W'(DEPTH - 1));
	assign div_last   = (step_q == STEP_W'(SUM_W - 1));
	assign slot_free  = !out_valid_q || out_ready;

	// Decode commands from the state and step counter
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_FILL: begin
				cmd.shift_in = take;
			end
			ST_SORT: begin
				cmd.sort_en  = 1'b1;
				cmd.sort_odd = step_q[0];
				cmd.acc_clr  = 1'b1;
			end
			ST_SCAN: begin
				cmd.scan_en   = 1'b1;
				cmd.scan_edge = (step_q == '0) || pass_last;
				cmd.scan_acc  = (step_q != '0);
			end
			ST_DIV: begin
				cmd.div_en = 1'b1;
			end
			ST_EMIT: begin
				cmd.out_load = slot_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// Advance state, counters and the result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FILL;
			fill_q      <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_FILL: begin
					if (take) begin
						step_q <= '0;
						if (batch_last) begin
							fill_q  <= '0;
							state_q <= ST_SORT;
						end else begin
							fill_q <= fill_q + 1'b1;
						end
					end
				end
				ST_SORT: begin
					if (pass_last) begin
						step_q  <= '0;
						state_q <= ST_SCAN;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_SCAN: begin
					if (pass_last) begin
						step_q  <= '0;
						state_q <= ST_DIV;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_DIV: begin
					if (div_last) begin
						step_q  <= '0;
						state_q <= ST_EMIT;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						state_q <= ST_FILL;
					end
				end
				default: begin
					state_q <= ST_FILL;
				end
			endcase
		end
	end

endmodule

// ----- rtl/sbdm_dpath.sv -----
// Datapath: sample shift store, transposition sorter, despike scan, divider.
module sbdm_dpath #(
	parameter int DEPTH = sbdm_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  sbdm_pkg::cmd_t                cmd,
	input  logic [sbdm_pkg::THR_W-1:0]    threshold,
	input  logic [sbdm_pkg::SAMPLE_W-1:0] sample_value,
	output sbdm_pkg::status_t             status,
	output logic [sbdm_pkg::MEAN_W-1:0]   mean_value,
	output logic [sbdm_pkg::COUNT_W-1:0]  used_count,
	output logic                          none_valid
);
	import sbdm_pkg::*;

	localparam int SUM_W = MEAN_W + $clog2(DEPTH);

	logic [MEAN_W-1:0]  store_q [DEPTH];
	logic [MEAN_W-1:0]  sorted [DEPTH];
	logic [MEAN_W-1:0]  left_q;
	logic [SUM_W-1:0]   acc_q;
	logic [COUNT_W-1:0] used_q;
	logic [COUNT_W-1:0] rem_q;
	logic [MEAN_W-1:0]  mean_q;
	logic [COUNT_W-1:0] count_q;
	logic               none_q;

	logic [MEAN_W-1:0]  mid;
	logic [MEAN_W-1:0]  right;
	logic [MEAN_W-1:0]  limit;
	logic [MEAN_W:0]    pair_sum;
	logic               spike;
	logic [MEAN_W-1:0]  scan_val;
	logic [COUNT_W:0]   rem_w;
	logic [COUNT_W:0]   rem_diff;
	logic               q_bit;

	function automatic logic [MEAN_W-1:0] gap(input logic [MEAN_W-1:0] a,
		input logic [MEAN_W-1:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	assign status.sample_nz = (sample_value != '0);

	// One transposition pass: swap out-of-order pairs of the current parity
	always_comb begin
		sorted = store_q;
		for (int i = 0; i < DEPTH - 1; i++) begin
			if ((i[0] == cmd.sort_odd) && (store_q[i] > store_q[i + 1])) begin
				sorted[i]     = store_q[i + 1];
				sorted[i + 1] = store_q[i];
			end
		end
	end

	// Despike window: repaired left neighbor, head of store, next entry
	assign mid      = store_q[0];
	assign right    = store_q[1];
	assign limit    = {threshold, {FRAC_W{1'b0}}};
	assign pair_sum = {1'b0, left_q} + {1'b0, right};
	assign spike    = !cmd.scan_edge && (gap(mid, right) > limit) && (gap(mid, left_q) > limit);
	assign scan_val = spike ? pair_sum[MEAN_W:1] : mid;

	// Restoring division step, one quotient bit a cycle
	assign rem_w    = {rem_q, acc_q[SUM_W-1]};
	assign rem_diff = rem_w - {1'b0, used_q};
	assign q_bit    = (rem_w >= {1'b0, used_q});

	// Shift samples in, sort, or rotate the store through the scan window
	always_ff @(posedge clk) begin
		if (cmd.shift_in) begin
			for (int i = 0; i < DEPTH - 1; i++) begin
				store_q[i] <= store_q[i + 1];
			end
			store_q[DEPTH-1] <= {sample_value, {FRAC_W{1'b0}}};
		end else if (cmd.sort_en) begin
			store_q <= sorted;
		end else if (cmd.scan_en) begin
			for (int i = 0; i < DEPTH - 1; i++) begin
				store_q[i] <= store_q[i + 1];
			end
			store_q[DEPTH-1] <= scan_val;
		end
	end

	// Accumulate kept entries, then divide the sum in place
	always_ff @(posedge clk) begin
		if (cmd.acc_clr) begin
			acc_q  <= '0;
			used_q <= '0;
			rem_q  <= '0;
		end else if (cmd.scan_en) begin
			left_q <= scan_val;
			if (cmd.scan_acc && (scan_val != '0)) begin
				acc_q  <= acc_q + SUM_W'(scan_val);
				used_q <= used_q + 1'b1;
			end
		end else if (cmd.div_en) begin
			acc_q <= {acc_q[SUM_W-2:0], q_bit};
			rem_q <= q_bit ? rem_diff[COUNT_W-1:0] : rem_w[COUNT_W-1:0];
		end
	end

	// Hold the result transaction until the controller loads the next one
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			mean_q  <= (used_q == '0) ? '0 : acc_q[MEAN_W-1:0];
			count_q <= used_q;
			none_q  <= (used_q == '0);
		end
	end

	assign mean_value = mean_q;
	assign used_count = count_q;
	assign none_valid = none_q;

endmodule

// ----- rtl/sorted_batch_despike_mean.sv -----
// Batch despike and mean filter: collects DEPTH nonzero samples, sorts the
// batch, replaces isolated spikes by the average of their neighbors and
// returns the truncated Q16.4 mean of entries 1 to DEPTH-1.
// Input channel: in_valid/in_ready with sample_value. A zero sample is
// accepted and dropped. Output channel: out_valid/out_ready with
// mean_value, used_count and none_valid, one transaction per full batch.
// The spike threshold is written over the APB port at offset 0.
// While the batch fills, in_ready stays high and samples are accepted
// back to back. After the sample that completes a batch, in_ready stays
// low through DEPTH sort passes, DEPTH scan steps, 20 + clog2(DEPTH)
// divider steps and the wait for a free slot to load the result.
// The sort is an odd-even transposition sorter over the store, the scan
// rotates the store through a three-entry window, and the divider yields
// one quotient bit per cycle.
// Reset clears the controller, the fill count and the result valid flag and
// sets the threshold to 50. A stalled receiver holds the result; the next
// batch fills meanwhile and waits before its result is loaded.
module sorted_batch_despike_mean #(
	parameter int DEPTH = sbdm_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [sbdm_pkg::SAMPLE_W-1:0] sample_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [sbdm_pkg::MEAN_W-1:0]   mean_value,
	output logic [sbdm_pkg::COUNT_W-1:0]  used_count,
	output logic                          none_valid,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sbdm_pkg::ADDR_W-1:0]   paddr,
	input  logic [sbdm_pkg::DATA_W-1:0]   pwdata,
	output logic [sbdm_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);
	import sbdm_pkg::*;

	`include "sorted_batch_despike_mean_assert.svh"

	cmd_t             cmd;
	status_t          status;
	logic [THR_W-1:0] threshold;

	sbdm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.threshold (threshold)
	);

	sbdm_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	sbdm_dpath #(.DEPTH(DEPTH)) u_dpath (
		.clk          (clk),
		.cmd          (cmd),
		.threshold    (threshold),
		.sample_value (sample_value),
		.status       (status),
		.mean_value   (mean_value),
		.used_count   (used_count),
		.none_valid   (none_valid)
	);

	// Batch work never overlaps with sample intake
	`SBDM_ASSERT_NOW(a_idle_when_ready, in_ready, !(cmd.sort_en || cmd.scan_en || cmd.div_en), "batch work while accepting samples")
	// A result is loaded only into a free or draining slot
	`SBDM_ASSERT_NOW(a_load_slot_free, cmd.out_load, !out_valid || out_ready, "result overwritten before transfer")
	// A loaded result is presented in the next cycle
	`SBDM_ASSERT_NEXT(a_load_shows, cmd.out_load, out_valid, "loaded result not presented")
	// The empty flag agrees with the count and forces a zero mean
	`SBDM_ASSERT_NOW(a_none_consistent, out_valid, (none_valid == (used_count == '0)) && (!none_valid || (mean_value == '0)), "empty flag inconsistent with result")

endmodule

// ----- tb/tb.sv -----
// Testbench for sorted_batch_despike_mean: directed and random samples checked against a batch model.
`timescale 1ns / 100ps

module tb;
	import sbdm_pkg::*;

	localparam int DEPTH         = DEPTH_DEF;
	localparam int SETTLE_CYCLES = 80;
	localparam int STALL_LIMIT   = 4000;

	typedef struct packed {
		logic [MEAN_W-1:0]  mean;
		logic [COUNT_W-1:0] used;
		logic               none;
	} batch_mean_t;

	logic                clk;
	logic                arst_n       = 1'b0;
	logic                in_valid     = 1'b0;
	logic                in_ready;
	logic [SAMPLE_W-1:0] sample_value = '0;
	logic                out_valid;
	logic                out_ready    = 1'b0;
	logic [MEAN_W-1:0]   mean_value;
	logic [COUNT_W-1:0]  used_count;
	logic                none_valid;
	logic                psel         = 1'b0;
	logic                penable      = 1'b0;
	logic                pwrite       = 1'b0;
	logic [ADDR_W-1:0]   paddr        = '0;
	logic [DATA_W-1:0]   pwdata       = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	sorted_batch_despike_mean u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample_value (sample_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.mean_value   (mean_value),
		.used_count   (used_count),
		.none_valid   (none_valid),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	// Model state of the filter
	logic [MEAN_W-1:0]   batch_store [DEPTH];
	int                  batch_fill = 0;
	logic [THR_W-1:0]    spike_thr  = THR_RESET;

	logic [SAMPLE_W-1:0] sample_q [$];
	batch_mean_t         mean_q [$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	logic in_hs = 1'b0;
	int stall_cycles = 0;
	int fail_count = 0;
	int samples_taken = 0;
	int zeros_taken = 0;
	int batches_checked = 0;
	int spikes_replaced = 0;

	// Random cluster generator state
	int cluster_center = 1000;
	int cluster_spread = 20;
	int cluster_left = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [31:0] abs_gap(input logic [31:0] a, input logic [31:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	// Append one sample; on a full batch sort, despike and queue the expected mean
	task automatic fold_sample(input logic [SAMPLE_W-1:0] s);
		logic [MEAN_W-1:0] v;
		logic [31:0]       lim;
		logic [31:0]       sum;
		int                used;
		int                i;
		int                j;
		batch_mean_t       r;
		if (s == '0) begin
			zeros_taken++;
			return;
		end
		batch_store[batch_fill] = {s, {FRAC_W{1'b0}}};
		batch_fill++;
		if (batch_fill < DEPTH)
			return;
		for (i = 1; i < DEPTH; i++) begin
			v = batch_store[i];
			j = i;
			while (j > 0 && batch_store[j-1] > v) begin
				batch_store[j] = batch_store[j-1];
				j--;
			end
			batch_store[j] = v;
		end
		lim = 32'(spike_thr) << FRAC_W;
		for (i = 1; i <= DEPTH - 2; i++) begin
			if (abs_gap(batch_store[i], batch_store[i+1]) > lim &&
			    abs_gap(batch_store[i], batch_store[i-1]) > lim) begin
				batch_store[i] = MEAN_W'((32'(batch_store[i-1]) + 32'(batch_store[i+1])) >> 1);
				spikes_replaced++;
			end
		end
		sum = 0;
		used = 0;
		for (i = 1; i <= DEPTH - 1; i++) begin
			if (batch_store[i] != '0) begin
				sum += 32'(batch_store[i]);
				used++;
			end
		end
		r.mean = (used != 0) ? MEAN_W'(sum / used) : '0;
		r.used = COUNT_W'(used);
		r.none = (used == 0);
		mean_q.push_back(r);
		for (i = 0; i < DEPTH; i++)
			batch_store[i] = '0;
		batch_fill = 0;
	endtask

	// Queue n samples: mostly clustered batches with spikes, some zeros and noise
	task automatic queue_random_samples(input int n);
		int k;
		int pick;
		int v;
		for (k = 0; k < n; k++) begin
			if (cluster_left == 0) begin
				cluster_center = $urandom_range(1, 65535);
				case ($urandom_range(0, 3))
					0: cluster_spread = 2;
					1: cluster_spread = 20;
					2: cluster_spread = 200;
					default: cluster_spread = 3000;
				endcase
				cluster_left = DEPTH;
			end
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				sample_q.push_back('0);
				continue;
			end else if (pick < 14) begin
				v = $urandom_range(0, 65535);
			end else if (pick < 26) begin
				v = int'($urandom_range(500, 20000));
				v = ($urandom_range(0, 1) != 0) ? cluster_center + v : cluster_center - v;
			end else begin
				v = cluster_center + int'($urandom_range(0, 2 * cluster_spread)) - cluster_spread;
			end
			if (v < 1)
				v = 1;
			if (v > 65535)
				v = 65535;
			sample_q.push_back(SAMPLE_W'(v));
			cluster_left--;
		end
	endtask

	// Hold until every queued sample is sent and every mean has come back
	task automatic wait_drained();
		while (sample_q.size() != 0 || in_valid || mean_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write of the spike threshold: setup cycle, then access cycle
	task automatic write_threshold(input logic [THR_W-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= REG_SPIKE_THRESHOLD;
		pwdata  <= DATA_W'(value);
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		spike_thr = value;
	endtask

	// Driver: advance to the next sample after each accepted transaction
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_hs) begin
			if (sample_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				in_valid     <= 1'b1;
				sample_value <= sample_q.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver stalls at random
	always @(negedge clk) begin
		out_ready <= arst_n && ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// Monitor: predict on accepted samples, check accepted means
	always @(posedge clk) begin
		batch_mean_t want;
		in_hs <= arst_n && in_valid && in_ready;
		if (arst_n && in_valid && in_ready) begin
			samples_taken++;
			fold_sample(sample_value);
		end
		if (arst_n && out_valid && out_ready) begin
			if (mean_q.size() == 0) begin
				$error("unexpected result: mean_value=%0h used_count=%0d none_valid=%0b",
					mean_value, used_count, none_valid);
				fail_count++;
			end else begin
				want = mean_q.pop_front();
				batches_checked++;
				if (mean_value !== want.mean) begin
					$error("mean_value: expected %0h, got %0h", want.mean, mean_value);
					fail_count++;
				end
				if (used_count !== want.used) begin
					$error("used_count: expected %0d, got %0d", want.used, used_count);
					fail_count++;
				end
				if (none_valid !== want.none) begin
					$error("none_valid: expected %0b, got %0b", want.none, none_valid);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: count cycles without any transaction
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("watchdog expired after %0d idle cycles", STALL_LIMIT);
		$display("sorted_batch_despike_mean verification failed");
		$finish;
	end

	initial begin
		logic [THR_W-1:0] mid_thr;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: extremes, dropped zeros, a low outlier and a high spike pair
		send_idle_pct = 36;
		recv_idle_pct = 57;
		sample_q = '{16'd0, 16'd65535, 16'd1, 16'd0, 16'd800, 16'd810, 16'd2000,
			16'd820, 16'd830, 16'd840, 16'd850, 16'd860};
		// Alternating bit patterns, then two samples and a zero that start the next batch
		sample_q = {sample_q, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
			16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
			16'd100, 16'd0, 16'd3000};
		wait_drained();

		write_threshold('0);
		queue_random_samples(120);
		wait_drained();

		send_idle_pct = 57;
		recv_idle_pct = 36;
		write_threshold('1);
		queue_random_samples(60);
		wait_drained();

		mid_thr = THR_W'($urandom_range(1, 400));
		write_threshold(mid_thr);
		queue_random_samples(126);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_threshold(THR_W'(1));
		queue_random_samples(120);
		wait_drained();

		$display("Sent %0d samples (%0d zero) over thresholds 50, 0, 65535, %0d and 1.",
			samples_taken, zeros_taken, mid_thr);
		$display("Checked %0d batch means with %0d spike replacements.",
			batches_checked, spikes_replaced);
		if (fail_count == 0)
			$display("sorted_batch_despike_mean verification clean");
		else
			$display("sorted_batch_despike_mean verification failed");
		$finish;
	end

endmodule
